// File: sv/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg: shared types and constants of the block range decomposer
// Command and status codes, register indexes and the word layouts of the
// item and result channels.
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int MAX_BLOCKS_I = 8;
    localparam int MAX_BLOCKS_J = 8;
    localparam int COORD_BITS   = 16;
    localparam int SET_BITS     = 8;
    localparam int DOM_BITS     = 14;
    localparam int MAX_RESULTS  = 64;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    typedef enum logic [1:0] {
        CMD_APPEND_I = 2'd0,
        CMD_APPEND_J = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_QUERY    = 2'd1,
        ST_LOAD_REFUSED = 2'd2
    } status_t;

    localparam logic [1:0] REG_BLOCKS_I = 2'd0;
    localparam logic [1:0] REG_BLOCKS_J = 2'd1;
    localparam logic [1:0] REG_NUM_SETS = 2'd2;

    typedef struct packed {
        cmd_t                  cmd;
        logic [COORD_BITS-1:0] block_size;
        logic [COORD_BITS-1:0] begin_i;
        logic [COORD_BITS-1:0] begin_j;
        logic [COORD_BITS-1:0] end_i;
        logic [COORD_BITS-1:0] end_j;
        logic [SET_BITS-1:0]   set_index;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [DOM_BITS-1:0]   domain;
        logic [COORD_BITS-1:0] local_begin_i;
        logic [COORD_BITS-1:0] local_begin_j;
        logic [COORD_BITS-1:0] local_end_i;
        logic [COORD_BITS-1:0] local_end_j;
        logic                  last;
    } out_result_t;

endpackage

// File: sv/brd_ram.sv
// ----------------------------------------------------------------------------
// brd_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module brd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/block_range_decomposer.sv
// ----------------------------------------------------------------------------
// block_range_decomposer: covering blocks of a rectangle in a block grid
// Keeps I and J prefix-offset tables in two small RAMs and walks the
// covering blocks of a query with one shared add/subtract unit.
// ----------------------------------------------------------------------------
// Clear: result word the cycle after the item is taken; append: after a table read and check.
// Query: checks of range and tables (S_Q_RD, S_Q_CHK), a search of both tables (S_SCAN) and
//   a size check (S_SIZE); a failed check ends it. Then S_ROW_* per covered J row, S_CELL_* per word.
// One item at a time: s_ready is high again the cycle after the last word goes.
// Reset (aresetn low, synchronous) empties both tables and sets the three config registers
//   to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_range_decomposer #(
    parameter int MAX_BLOCKS_I = brd_pkg::MAX_BLOCKS_I,
    parameter int MAX_BLOCKS_J = brd_pkg::MAX_BLOCKS_J
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  brd_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output brd_pkg::out_result_t              m_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [brd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [brd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int IDX_I_W = $clog2(MAX_BLOCKS_I + 1);
    localparam int IDX_J_W = $clog2(MAX_BLOCKS_J + 1);
    localparam int MAX_B   = (MAX_BLOCKS_I > MAX_BLOCKS_J) ? MAX_BLOCKS_I : MAX_BLOCKS_J;
    localparam int CNT_W   = $clog2(MAX_B + 2);
    localparam int SPAN_W  = IDX_I_W + IDX_J_W;
    localparam int COORD_W = brd_pkg::COORD_BITS;
    localparam int DOM_W   = brd_pkg::DOM_BITS;
    localparam int DATA_W  = brd_pkg::APB_DATA_W;

    localparam logic [1:0] REG_BLOCKS_I_SEL = brd_pkg::REG_BLOCKS_I;
    localparam logic [1:0] REG_BLOCKS_J_SEL = brd_pkg::REG_BLOCKS_J;
    localparam logic [1:0] REG_NUM_SETS_SEL = brd_pkg::REG_NUM_SETS;

    typedef enum logic [18:0] {
        S_IDLE    = 19'd1 << 0,
        S_LD_RD   = 19'd1 << 1,
        S_LD_CHK  = 19'd1 << 2,
        S_Q_RD    = 19'd1 << 3,
        S_Q_CHK   = 19'd1 << 4,
        S_SCAN    = 19'd1 << 5,
        S_SIZE    = 19'd1 << 6,
        S_BASE    = 19'd1 << 7,
        S_ROW_LO  = 19'd1 << 8,
        S_ROW_HI  = 19'd1 << 9,
        S_ROW_B   = 19'd1 << 10,
        S_ROW_C   = 19'd1 << 11,
        S_ROW_E   = 19'd1 << 12,
        S_CELL_LO = 19'd1 << 13,
        S_CELL_HI = 19'd1 << 14,
        S_CELL_B  = 19'd1 << 15,
        S_CELL_C  = 19'd1 << 16,
        S_CELL_E  = 19'd1 << 17,
        S_EMIT    = 19'd1 << 18
    } state_t;

    // control state
    state_t             state_reg, state_next;
    logic [3:0]         blocks_i_reg, blocks_i_next;
    logic [3:0]         blocks_j_reg, blocks_j_next;
    logic [8:0]         num_sets_reg, num_sets_next;
    logic [IDX_I_W-1:0] loaded_i_reg, loaded_i_next;
    logic [IDX_J_W-1:0] loaded_j_reg, loaded_j_next;
    logic               scan_pend_reg, scan_pend_next;

    // datapath
    brd_pkg::in_item_t    item_reg, item_next;
    brd_pkg::out_result_t res_reg, res_next;
    logic               cell_reg, cell_next;
    logic [COORD_W-1:0] lo_reg, lo_next, hi_reg, hi_next, mn_reg, mn_next;
    logic [COORD_W-1:0] lbi_reg, lbi_next, lbj_reg, lbj_next, lej_reg, lej_next;
    logic [IDX_I_W-1:0] ib0_reg, ib0_next, ib1_reg, ib1_next, ib_reg, ib_next;
    logic [IDX_J_W-1:0] jb0_reg, jb0_next, jb1_reg, jb1_next, jb_reg, jb_next;
    logic               found_i_reg, found_i_next, found_j_reg, found_j_next;
    logic [CNT_W-1:0]   scan_t_reg, scan_t_next, scan_tp_reg, scan_tp_next;
    logic [CNT_W-1:0]   tmax_reg, tmax_next;
    logic [DOM_W-1:0]   prod_sb_reg, prod_sb_next, jbbi_reg, jbbi_next;
    logic [DOM_W-1:0]   row_base_reg, row_base_next;
    logic               ri_zero_reg, rj_zero_reg;

    // table RAM ports
    logic               ri_wr_en, rj_wr_en;
    logic [IDX_I_W-1:0] ri_wr_addr, ri_rd_addr;
    logic [IDX_J_W-1:0] rj_wr_addr, rj_rd_addr;
    logic [COORD_W-1:0] ri_rd_data, rj_rd_data, tab_i_val, tab_j_val;

    // shared add/subtract unit
    logic [COORD_W-1:0] alu_a, alu_b;
    logic               alu_sub;
    logic [COORD_W:0]   alu_res;

    logic               cfg_wr, cfg_ok_i, cfg_ok_j, full_i, full_j;
    logic [IDX_I_W-1:0] n_i, span_i;
    logic [IDX_J_W-1:0] n_j, span_j;
    logic [SPAN_W-1:0]  span_prod;
    logic               scan_issue, ib_last, jb_last;

    brd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_BLOCKS_I + 1)) u_ram_i (
        .aclk    (aclk),
        .wr_en   (ri_wr_en),
        .wr_addr (ri_wr_addr),
        .wr_data (alu_res[COORD_W-1:0]),
        .rd_addr (ri_rd_addr),
        .rd_data (ri_rd_data)
    );

    brd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_BLOCKS_J + 1)) u_ram_j (
        .aclk    (aclk),
        .wr_en   (rj_wr_en),
        .wr_addr (rj_wr_addr),
        .wr_data (alu_res[COORD_W-1:0]),
        .rd_addr (rj_rd_addr),
        .rd_data (rj_rd_data)
    );

    // entry 0 is never written: read it as zero
    assign tab_i_val = ri_zero_reg ? '0 : ri_rd_data;
    assign tab_j_val = rj_zero_reg ? '0 : rj_rd_data;

    assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});

    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_ok_i = (blocks_i_reg != '0) && (32'(blocks_i_reg) <= MAX_BLOCKS_I)
                      && (32'(blocks_i_reg) <= 32'(loaded_i_reg));
    assign cfg_ok_j = (blocks_j_reg != '0) && (32'(blocks_j_reg) <= MAX_BLOCKS_J)
                      && (32'(blocks_j_reg) <= 32'(loaded_j_reg));
    assign full_i   = 32'(loaded_i_reg) >= MAX_BLOCKS_I;
    assign full_j   = 32'(loaded_j_reg) >= MAX_BLOCKS_J;
    assign n_i      = IDX_I_W'(blocks_i_reg);
    assign n_j      = IDX_J_W'(blocks_j_reg);
    assign span_i   = ib1_reg - ib0_reg;
    assign span_j   = jb1_reg - jb0_reg;
    assign span_prod  = SPAN_W'(span_i) * SPAN_W'(span_j);
    assign scan_issue = scan_t_reg <= tmax_reg;
    assign ib_last  = (ib_reg + IDX_I_W'(1)) == ib1_reg;
    assign jb_last  = (jb_reg + IDX_J_W'(1)) == jb1_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_EMIT);
    assign m_result = res_reg;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_BLOCKS_I_SEL: prdata = DATA_W'(blocks_i_reg);
            REG_BLOCKS_J_SEL: prdata = DATA_W'(blocks_j_reg);
            REG_NUM_SETS_SEL: prdata = DATA_W'(num_sets_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        blocks_i_next  = blocks_i_reg;
        blocks_j_next  = blocks_j_reg;
        num_sets_next  = num_sets_reg;
        loaded_i_next  = loaded_i_reg;
        loaded_j_next  = loaded_j_reg;
        scan_pend_next = scan_pend_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        cell_next      = cell_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mn_next        = mn_reg;
        lbi_next       = lbi_reg;
        lbj_next       = lbj_reg;
        lej_next       = lej_reg;
        ib0_next       = ib0_reg;
        ib1_next       = ib1_reg;
        ib_next        = ib_reg;
        jb0_next       = jb0_reg;
        jb1_next       = jb1_reg;
        jb_next        = jb_reg;
        found_i_next   = found_i_reg;
        found_j_next   = found_j_reg;
        scan_t_next    = scan_t_reg;
        scan_tp_next   = scan_tp_reg;
        tmax_next      = tmax_reg;
        prod_sb_next   = prod_sb_reg;
        jbbi_next      = jbbi_reg;
        row_base_next  = row_base_reg;
        ri_wr_en       = 1'b0;
        rj_wr_en       = 1'b0;
        ri_wr_addr     = loaded_i_reg + IDX_I_W'(1);
        rj_wr_addr     = loaded_j_reg + IDX_J_W'(1);
        ri_rd_addr     = '0;
        rj_rd_addr     = '0;
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b1;

        if (cfg_wr) begin
            case (paddr[3:2])
                REG_BLOCKS_I_SEL: blocks_i_next = pwdata[3:0];
                REG_BLOCKS_J_SEL: blocks_j_next = pwdata[3:0];
                REG_NUM_SETS_SEL: num_sets_next = pwdata[8:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_item;
                    res_next  = '0;
                    res_next.status = brd_pkg::ST_OK;
                    res_next.last   = 1'b1;
                    cell_next = 1'b0;
                    case (s_item.cmd)
                        brd_pkg::CMD_APPEND_I, brd_pkg::CMD_APPEND_J: begin
                            state_next = S_LD_RD;
                        end
                        brd_pkg::CMD_QUERY: begin
                            state_next = S_Q_RD;
                        end
                        brd_pkg::CMD_CLEAR: begin
                            loaded_i_next = '0;
                            loaded_j_next = '0;
                            state_next    = S_EMIT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_LD_RD: begin
                ri_rd_addr = loaded_i_reg;
                rj_rd_addr = loaded_j_reg;
                state_next = S_LD_CHK;
            end
            S_LD_CHK: begin
                alu_sub = 1'b0;
                alu_b   = item_reg.block_size;
                if (item_reg.cmd == brd_pkg::CMD_APPEND_I) begin
                    alu_a = tab_i_val;
                    if (full_i || item_reg.block_size == '0 || alu_res[COORD_W]) begin
                        res_next.status = brd_pkg::ST_LOAD_REFUSED;
                    end else begin
                        ri_wr_en      = 1'b1;
                        loaded_i_next = loaded_i_reg + IDX_I_W'(1);
                    end
                end else begin
                    alu_a = tab_j_val;
                    if (full_j || item_reg.block_size == '0 || alu_res[COORD_W]) begin
                        res_next.status = brd_pkg::ST_LOAD_REFUSED;
                    end else begin
                        rj_wr_en      = 1'b1;
                        loaded_j_next = loaded_j_reg + IDX_J_W'(1);
                    end
                end
                state_next = S_EMIT;
            end
            S_Q_RD: begin
                // fetch the axis totals
                ri_rd_addr = cfg_ok_i ? n_i : '0;
                rj_rd_addr = cfg_ok_j ? n_j : '0;
                state_next = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (!cfg_ok_i || !cfg_ok_j
                    || item_reg.begin_i >= item_reg.end_i
                    || item_reg.begin_j >= item_reg.end_j
                    || item_reg.end_i > tab_i_val || item_reg.end_j > tab_j_val
                    || {1'b0, item_reg.set_index} >= num_sets_reg) begin
                    res_next.status = brd_pkg::ST_BAD_QUERY;
                    state_next      = S_EMIT;
                end else begin
                    ib0_next       = '0;
                    ib1_next       = n_i;
                    jb0_next       = '0;
                    jb1_next       = n_j;
                    found_i_next   = 1'b0;
                    found_j_next   = 1'b0;
                    scan_t_next    = CNT_W'(1);
                    scan_pend_next = 1'b0;
                    tmax_next      = (blocks_i_reg > blocks_j_reg) ? CNT_W'(blocks_i_reg)
                                                                   : CNT_W'(blocks_j_reg);
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                // read entry t while comparing entry t-1 of both tables
                ri_rd_addr = (32'(scan_t_reg) > 32'(blocks_i_reg)) ? n_i
                                                                   : IDX_I_W'(scan_t_reg);
                rj_rd_addr = (32'(scan_t_reg) > 32'(blocks_j_reg)) ? n_j
                                                                   : IDX_J_W'(scan_t_reg);
                if (scan_issue) begin
                    scan_t_next = scan_t_reg + CNT_W'(1);
                end
                scan_pend_next = scan_issue;
                scan_tp_next   = scan_t_reg;
                if (scan_pend_reg) begin
                    if (32'(scan_tp_reg) <= 32'(blocks_i_reg)) begin
                        if (tab_i_val <= item_reg.begin_i) begin
                            ib0_next = IDX_I_W'(scan_tp_reg);
                        end
                        if (!found_i_reg && tab_i_val >= item_reg.end_i) begin
                            ib1_next     = IDX_I_W'(scan_tp_reg);
                            found_i_next = 1'b1;
                        end
                    end
                    if (32'(scan_tp_reg) <= 32'(blocks_j_reg)) begin
                        if (tab_j_val <= item_reg.begin_j) begin
                            jb0_next = IDX_J_W'(scan_tp_reg);
                        end
                        if (!found_j_reg && tab_j_val >= item_reg.end_j) begin
                            jb1_next     = IDX_J_W'(scan_tp_reg);
                            found_j_next = 1'b1;
                        end
                    end
                end
                if (!scan_issue && !scan_pend_reg) begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE: begin
                if (ib0_reg >= ib1_reg || jb0_reg >= jb1_reg
                    || 32'(span_prod) > brd_pkg::MAX_RESULTS) begin
                    res_next.status = brd_pkg::ST_BAD_QUERY;
                    state_next      = S_EMIT;
                end else begin
                    prod_sb_next = DOM_W'(item_reg.set_index) * DOM_W'(blocks_i_reg);
                    jbbi_next    = DOM_W'(jb0_reg) * DOM_W'(blocks_i_reg);
                    ib_next      = ib0_reg;
                    jb_next      = jb0_reg;
                    state_next   = S_BASE;
                end
            end
            S_BASE: begin
                row_base_next = (prod_sb_reg * DOM_W'(blocks_j_reg)) + jbbi_reg;
                state_next    = S_ROW_LO;
            end
            S_ROW_LO: begin
                rj_rd_addr = jb_reg;
                state_next = S_ROW_HI;
            end
            S_ROW_HI: begin
                rj_rd_addr = jb_reg + IDX_J_W'(1);
                lo_next    = tab_j_val;
                state_next = S_ROW_B;
            end
            S_ROW_B: begin
                hi_next    = tab_j_val;
                alu_a      = item_reg.begin_j;
                alu_b      = lo_reg;
                lbj_next   = alu_res[COORD_W] ? '0 : alu_res[COORD_W-1:0];
                state_next = S_ROW_C;
            end
            S_ROW_C: begin
                alu_a      = item_reg.end_j;
                alu_b      = hi_reg;
                mn_next    = alu_res[COORD_W] ? item_reg.end_j : hi_reg;
                state_next = S_ROW_E;
            end
            S_ROW_E: begin
                alu_a      = mn_reg;
                alu_b      = lo_reg;
                lej_next   = alu_res[COORD_W-1:0];
                state_next = S_CELL_LO;
            end
            S_CELL_LO: begin
                ri_rd_addr = ib_reg;
                state_next = S_CELL_HI;
            end
            S_CELL_HI: begin
                ri_rd_addr = ib_reg + IDX_I_W'(1);
                lo_next    = tab_i_val;
                state_next = S_CELL_B;
            end
            S_CELL_B: begin
                hi_next    = tab_i_val;
                alu_a      = item_reg.begin_i;
                alu_b      = lo_reg;
                lbi_next   = alu_res[COORD_W] ? '0 : alu_res[COORD_W-1:0];
                state_next = S_CELL_C;
            end
            S_CELL_C: begin
                alu_a      = item_reg.end_i;
                alu_b      = hi_reg;
                mn_next    = alu_res[COORD_W] ? item_reg.end_i : hi_reg;
                state_next = S_CELL_E;
            end
            S_CELL_E: begin
                alu_a = mn_reg;
                alu_b = lo_reg;
                res_next.status        = brd_pkg::ST_OK;
                res_next.domain        = row_base_reg + DOM_W'(ib_reg);
                res_next.local_begin_i = lbi_reg;
                res_next.local_end_i   = alu_res[COORD_W-1:0];
                res_next.local_begin_j = lbj_reg;
                res_next.local_end_j   = lej_reg;
                res_next.last          = ib_last && jb_last;
                cell_next              = 1'b1;
                state_next             = S_EMIT;
            end
            S_EMIT: begin
                if (m_ready) begin
                    if (!cell_reg) begin
                        state_next = S_IDLE;
                    end else if (!ib_last) begin
                        ib_next    = ib_reg + IDX_I_W'(1);
                        state_next = S_CELL_LO;
                    end else if (!jb_last) begin
                        // advance to the next J row
                        jb_next       = jb_reg + IDX_J_W'(1);
                        ib_next       = ib0_reg;
                        row_base_next = row_base_reg + DOM_W'(blocks_i_reg);
                        state_next    = S_ROW_LO;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            blocks_i_reg  <= 4'd1;
            blocks_j_reg  <= 4'd1;
            num_sets_reg  <= 9'd1;
            loaded_i_reg  <= '0;
            loaded_j_reg  <= '0;
            scan_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            blocks_i_reg  <= blocks_i_next;
            blocks_j_reg  <= blocks_j_next;
            num_sets_reg  <= num_sets_next;
            loaded_i_reg  <= loaded_i_next;
            loaded_j_reg  <= loaded_j_next;
            scan_pend_reg <= scan_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        cell_reg     <= cell_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mn_reg       <= mn_next;
        lbi_reg      <= lbi_next;
        lbj_reg      <= lbj_next;
        lej_reg      <= lej_next;
        ib0_reg      <= ib0_next;
        ib1_reg      <= ib1_next;
        ib_reg       <= ib_next;
        jb0_reg      <= jb0_next;
        jb1_reg      <= jb1_next;
        jb_reg       <= jb_next;
        found_i_reg  <= found_i_next;
        found_j_reg  <= found_j_next;
        scan_t_reg   <= scan_t_next;
        scan_tp_reg  <= scan_tp_next;
        tmax_reg     <= tmax_next;
        prod_sb_reg  <= prod_sb_next;
        jbbi_reg     <= jbbi_next;
        row_base_reg <= row_base_next;
        ri_zero_reg  <= (ri_rd_addr == '0);
        rj_zero_reg  <= (rj_rd_addr == '0);
    end

    // one item at a time: never take a word while a result is pending
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while a result word is pending");

    a_loaded_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(loaded_i_reg) <= MAX_BLOCKS_I) && (32'(loaded_j_reg) <= MAX_BLOCKS_J))
        else $error("table fill count beyond its depth");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.status != brd_pkg::ST_OK) |-> m_result.last)
        else $error("error result word not marked last");

    a_clear_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.cmd == brd_pkg::CMD_CLEAR) |=>
            (m_valid && m_result.last && loaded_i_reg == '0 && loaded_j_reg == '0))
        else $error("clear did not answer in the next cycle");

endmodule
